[rtl/taylor_sine_cosine_defines.svh]
// taylor_sine_cosine_defines.svh
// Assertion macros for the Taylor sine/cosine unit.
// Expects signals named clock and reset in the scope where a macro is used.
`ifndef TAYLOR_SINE_COSINE_DEFINES_SVH
`define TAYLOR_SINE_COSINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TSC_ASSERT_IMPLY(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Implication whose consequent is checked after the delay given by n.
`define TSC_ASSERT_DELAY(label, pre, n, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> ##n (post)) \
      else $error(msg);

`endif

[rtl/tsc_pkg.sv]
// tsc_pkg.sv
// Widths, constants, reciprocal table, pipeline types and the series
// accumulate function shared by all Taylor sine/cosine modules. No dependencies.
`timescale 1ns / 1ps

package tsc_pkg;

   // Series length and derived cell count
   localparam int TERMS = 10;
   localparam int MAX_TERMS = 16;
   localparam int CELLS = TERMS - 1;

   // Port widths
   localparam int ANGLE_W = 32;
   localparam int VALUE_W = 32;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   // Angle reduction: |angle| <= 128 rad holds at most 20 whole turns
   localparam int MAX_TURNS = 20;
   localparam int TURN_BITS = $clog2(MAX_TURNS + 1);
   localparam int X56_W = 64;
   localparam logic [X56_W-1:0] TWO_PI_Q56 = 64'h0648_7ED5_110B_4612;
   localparam int REM_SHIFT = 8;

   // Series datapath widths (magnitudes in Q.48)
   localparam int FRAC_W = 48;
   localparam int R48_W = 51;
   localparam int R2_W = 54;
   localparam int TERM_W = 55;
   localparam int PROD_W = 61;
   localparam int RECIP_W = 63;
   localparam int RECIP_SHIFT = 64;
   localparam int SUM_W = 60;
   localparam int OUT_SHIFT = 18;
   localparam int HALF_W = 32;
   localparam int POW_W = $clog2(2 * MAX_TERMS);
   localparam int RECIP_DEPTH = 2 ** POW_W;

   localparam logic [TERM_W-1:0] ONE_Q48 = TERM_W'(1) << FRAC_W;
   localparam logic [TERM_W-1:0] TWO_PI_Q48 = TERM_W'(TWO_PI_Q56 >> REM_SHIFT);
   localparam logic [POW_W-1:0] SIN_FIRST_POWER = POW_W'(1);
   localparam logic [POW_W-1:0] COS_FIRST_POWER = POW_W'(0);

   // Pipeline depth from accept to result strobe
   localparam int SQUARE_STAGES = 2;
   localparam int CELL_STAGES = 4;
   localparam int FINISH_STAGES = 2;
   localparam int LATENCY = 1 + TURN_BITS + SQUARE_STAGES + CELL_STAGES * CELLS
                            + FINISH_STAGES;

   // Q0.64 reciprocals of k*(k-1), indexed by k; k below 2 never occurs
   localparam logic [63:0] ALL_ONES = '1;
   localparam logic [RECIP_W-1:0] RECIP_TABLE [RECIP_DEPTH] = '{
      RECIP_W'(0),                 RECIP_W'(0),
      RECIP_W'(ALL_ONES / 64'd2),   RECIP_W'(ALL_ONES / 64'd6),
      RECIP_W'(ALL_ONES / 64'd12),  RECIP_W'(ALL_ONES / 64'd20),
      RECIP_W'(ALL_ONES / 64'd30),  RECIP_W'(ALL_ONES / 64'd42),
      RECIP_W'(ALL_ONES / 64'd56),  RECIP_W'(ALL_ONES / 64'd72),
      RECIP_W'(ALL_ONES / 64'd90),  RECIP_W'(ALL_ONES / 64'd110),
      RECIP_W'(ALL_ONES / 64'd132), RECIP_W'(ALL_ONES / 64'd156),
      RECIP_W'(ALL_ONES / 64'd182), RECIP_W'(ALL_ONES / 64'd210),
      RECIP_W'(ALL_ONES / 64'd240), RECIP_W'(ALL_ONES / 64'd272),
      RECIP_W'(ALL_ONES / 64'd306), RECIP_W'(ALL_ONES / 64'd342),
      RECIP_W'(ALL_ONES / 64'd380), RECIP_W'(ALL_ONES / 64'd420),
      RECIP_W'(ALL_ONES / 64'd462), RECIP_W'(ALL_ONES / 64'd506),
      RECIP_W'(ALL_ONES / 64'd552), RECIP_W'(ALL_ONES / 64'd600),
      RECIP_W'(ALL_ONES / 64'd650), RECIP_W'(ALL_ONES / 64'd702),
      RECIP_W'(ALL_ONES / 64'd756), RECIP_W'(ALL_ONES / 64'd812),
      RECIP_W'(ALL_ONES / 64'd870), RECIP_W'(ALL_ONES / 64'd930)
   };

   // Control that travels with every item
   typedef struct packed {
      logic valid;
      logic cosine;
      logic neg_angle;
   } tsc_ctrl_type;

   // Series state handed from cell to cell
   typedef struct packed {
      logic [TERM_W-1:0]       term;
      logic [R2_W-1:0]         r2;
      logic signed [SUM_W-1:0] sum;
      logic [POW_W-1:0]        power;
      logic                    negate;
   } tsc_lane_type;

   // Add or subtract one unsigned term into the signed partial sum
   function automatic logic signed [SUM_W-1:0] tsc_accumulate(
      input logic signed [SUM_W-1:0] sum,
      input logic [TERM_W-1:0]       term,
      input logic                    negate
   );
      logic signed [SUM_W-1:0] ext;
      ext = $signed({{(SUM_W-TERM_W){1'b0}}, term});
      return negate ? (sum - ext) : (sum + ext);
   endfunction

endpackage

[rtl/tsc_reduce.sv]
// tsc_reduce.sv
// Front end: captures the transfer, removes whole turns of 2*pi one quotient
// bit per stage, squares the remainder and seeds the first cell. Uses tsc_pkg.
`timescale 1ns / 1ps

module tsc_reduce import tsc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      command,
   input  logic signed [ANGLE_W-1:0] angle,
   output tsc_ctrl_type              ctrl_o,
   output tsc_lane_type              lane_o
);

   localparam int LAST = TURN_BITS - 1;
   localparam int R48_HI_W = R48_W - HALF_W;
   localparam int SQ_W = 2 * R48_W;

   tsc_ctrl_type              cap_ctrl_ff, cap_ctrl_in;
   logic [ANGLE_W-1:0]        mag_ff, mag_in;
   tsc_ctrl_type              red_ctrl_ff [TURN_BITS];
   logic [X56_W-1:0]          rem_ff [TURN_BITS];
   logic [R48_W-1:0]          r48;
   tsc_ctrl_type              sq_ctrl_ff;
   logic [R48_W-1:0]          r48_ff;
   logic [2*HALF_W-1:0]       sq_ll_ff, sq_ll_in;
   logic [HALF_W+R48_HI_W-1:0] sq_lh_ff, sq_lh_in;
   logic [2*R48_HI_W-1:0]     sq_hh_ff, sq_hh_in;
   logic [SQ_W-1:0]           sq_full;
   tsc_ctrl_type              out_ctrl_ff;
   tsc_lane_type              out_lane_ff, out_lane_in;

   // Capture command, angle sign and angle magnitude
   always_comb begin
      cap_ctrl_in.valid = accept;
      cap_ctrl_in.cosine = command;
      cap_ctrl_in.neg_angle = angle[ANGLE_W-1];
      mag_in = angle[ANGLE_W-1] ? $unsigned(-angle) : $unsigned(angle);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ctrl_ff <= '0;
      end else begin
         cap_ctrl_ff <= cap_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
   end

   // Restoring reduction: each stage tries one multiple 2^j * 2*pi
   for (genvar i = 0; i < TURN_BITS; i++) begin : g_turn
      localparam logic [X56_W-1:0] STEP = TWO_PI_Q56 << (TURN_BITS - 1 - i);
      tsc_ctrl_type     ctrl_in;
      logic [X56_W-1:0] rem_src, rem_in;

      if (i == 0) begin : g_first
         assign ctrl_in = cap_ctrl_ff;
         assign rem_src = {mag_ff, {(X56_W-ANGLE_W){1'b0}}};
      end else begin : g_next
         assign ctrl_in = red_ctrl_ff[i-1];
         assign rem_src = rem_ff[i-1];
      end

      assign rem_in = (rem_src >= STEP) ? (rem_src - STEP) : rem_src;

      always_ff @(posedge clock) begin
         if (reset) begin
            red_ctrl_ff[i] <= '0;
         end else begin
            red_ctrl_ff[i] <= ctrl_in;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i] <= rem_in;
      end
   end

   // Square the Q.48 remainder as partial products; the cross term is doubled
   assign r48 = rem_ff[LAST][REM_SHIFT +: R48_W];

   always_comb begin
      sq_ll_in = r48[HALF_W-1:0] * r48[HALF_W-1:0];
      sq_lh_in = r48[HALF_W-1:0] * r48[R48_W-1:HALF_W];
      sq_hh_in = r48[R48_W-1:HALF_W] * r48[R48_W-1:HALF_W];
   end

   // Sum partial products and seed the first term of the series
   always_comb begin
      sq_full = SQ_W'(sq_ll_ff) + (SQ_W'(sq_lh_ff) << (HALF_W + 1))
                + (SQ_W'(sq_hh_ff) << (2 * HALF_W));
      out_lane_in.term = sq_ctrl_ff.cosine ? ONE_Q48 : TERM_W'(r48_ff);
      out_lane_in.r2 = sq_full[FRAC_W +: R2_W];
      out_lane_in.sum = '0;
      out_lane_in.power = sq_ctrl_ff.cosine ? COS_FIRST_POWER : SIN_FIRST_POWER;
      out_lane_in.negate = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ctrl_ff <= '0;
         out_ctrl_ff <= '0;
      end else begin
         sq_ctrl_ff <= red_ctrl_ff[LAST];
         out_ctrl_ff <= sq_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      r48_ff <= r48;
      sq_ll_ff <= sq_ll_in;
      sq_lh_ff <= sq_lh_in;
      sq_hh_ff <= sq_hh_in;
      out_lane_ff <= out_lane_in;
   end

   assign ctrl_o = out_ctrl_ff;
   assign lane_o = out_lane_ff;

endmodule

[rtl/tsc_cell.sv]
// tsc_cell.sv
// One series cell: folds the incoming term into the partial sum and forms
// the next term as term * r^2 / (k*(k-1)) over four stages. Uses tsc_pkg.
`timescale 1ns / 1ps

module tsc_cell import tsc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  tsc_ctrl_type ctrl_i,
   input  tsc_lane_type lane_i,
   output tsc_ctrl_type ctrl_o,
   output tsc_lane_type lane_o
);

   localparam int T_HI_W = TERM_W - HALF_W;
   localparam int R2_HI_W = R2_W - HALF_W;
   localparam int MUL1_W = TERM_W + R2_W;
   localparam int P_HI_W = PROD_W - HALF_W;
   localparam int RC_HI_W = RECIP_W - HALF_W;
   localparam int MUL2_W = PROD_W + RECIP_W;

   tsc_ctrl_type               c1_ctrl_ff, c2_ctrl_ff, c3_ctrl_ff, out_ctrl_ff;
   tsc_lane_type               c1_lane_ff, c1_lane_in, c2_lane_ff, c3_lane_ff;
   tsc_lane_type               out_lane_ff, out_lane_in;
   logic [2*HALF_W-1:0]        m1_ll_ff, m1_ll_in;
   logic [HALF_W+R2_HI_W-1:0]  m1_lh_ff, m1_lh_in;
   logic [T_HI_W+HALF_W-1:0]   m1_hl_ff, m1_hl_in;
   logic [T_HI_W+R2_HI_W-1:0]  m1_hh_ff, m1_hh_in;
   logic [MUL1_W-1:0]          mul1_full;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [RECIP_W-1:0]         recip;
   logic [2*HALF_W-1:0]        m2_ll_ff, m2_ll_in;
   logic [HALF_W+RC_HI_W-1:0]  m2_lh_ff, m2_lh_in;
   logic [P_HI_W+HALF_W-1:0]   m2_hl_ff, m2_hl_in;
   logic [P_HI_W+RC_HI_W-1:0]  m2_hh_ff, m2_hh_in;
   logic [MUL2_W-1:0]          mul2_full;

   // Stage 1: accumulate, advance power and sign, start term * r^2
   always_comb begin
      c1_lane_in = lane_i;
      c1_lane_in.sum = tsc_accumulate(lane_i.sum, lane_i.term, lane_i.negate);
      c1_lane_in.power = lane_i.power + POW_W'(2);
      c1_lane_in.negate = ~lane_i.negate;
      m1_ll_in = lane_i.term[HALF_W-1:0] * lane_i.r2[HALF_W-1:0];
      m1_lh_in = lane_i.term[HALF_W-1:0] * lane_i.r2[R2_W-1:HALF_W];
      m1_hl_in = lane_i.term[TERM_W-1:HALF_W] * lane_i.r2[HALF_W-1:0];
      m1_hh_in = lane_i.term[TERM_W-1:HALF_W] * lane_i.r2[R2_W-1:HALF_W];
   end

   // Stage 2: sum partial products, keep the Q.48 part
   always_comb begin
      mul1_full = MUL1_W'(m1_ll_ff) + (MUL1_W'(m1_lh_ff) << HALF_W)
                  + (MUL1_W'(m1_hl_ff) << HALF_W) + (MUL1_W'(m1_hh_ff) << (2 * HALF_W));
      prod_in = mul1_full[FRAC_W +: PROD_W];
   end

   // Stage 3: look up 1/(k*(k-1)) and start the reciprocal multiply
   always_comb begin
      recip = RECIP_TABLE[c2_lane_ff.power];
      m2_ll_in = prod_ff[HALF_W-1:0] * recip[HALF_W-1:0];
      m2_lh_in = prod_ff[HALF_W-1:0] * recip[RECIP_W-1:HALF_W];
      m2_hl_in = prod_ff[PROD_W-1:HALF_W] * recip[HALF_W-1:0];
      m2_hh_in = prod_ff[PROD_W-1:HALF_W] * recip[RECIP_W-1:HALF_W];
   end

   // Stage 4: sum partial products, drop the 64 fraction bits
   always_comb begin
      mul2_full = MUL2_W'(m2_ll_ff) + (MUL2_W'(m2_lh_ff) << HALF_W)
                  + (MUL2_W'(m2_hl_ff) << HALF_W) + (MUL2_W'(m2_hh_ff) << (2 * HALF_W));
      out_lane_in = c3_lane_ff;
      out_lane_in.term = mul2_full[RECIP_SHIFT +: TERM_W];
   end

   // Advance control through the cell
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ctrl_ff <= '0;
         c2_ctrl_ff <= '0;
         c3_ctrl_ff <= '0;
         out_ctrl_ff <= '0;
      end else begin
         c1_ctrl_ff <= ctrl_i;
         c2_ctrl_ff <= c1_ctrl_ff;
         c3_ctrl_ff <= c2_ctrl_ff;
         out_ctrl_ff <= c3_ctrl_ff;
      end
   end

   // Advance datapath through the cell
   always_ff @(posedge clock) begin
      c1_lane_ff <= c1_lane_in;
      m1_ll_ff <= m1_ll_in;
      m1_lh_ff <= m1_lh_in;
      m1_hl_ff <= m1_hl_in;
      m1_hh_ff <= m1_hh_in;
      c2_lane_ff <= c1_lane_ff;
      prod_ff <= prod_in;
      c3_lane_ff <= c2_lane_ff;
      m2_ll_ff <= m2_ll_in;
      m2_lh_ff <= m2_lh_in;
      m2_hl_ff <= m2_hl_in;
      m2_hh_ff <= m2_hh_in;
      out_lane_ff <= out_lane_in;
   end

   assign ctrl_o = out_ctrl_ff;
   assign lane_o = out_lane_ff;

endmodule

[rtl/tsc_finish.sv]
// tsc_finish.sv
// Back end: adds the last term, converts the Q.48 sum to Q2.30 with the
// sine sign fix and saturation, and drives the result strobe. Uses tsc_pkg.
`timescale 1ns / 1ps

module tsc_finish import tsc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  tsc_ctrl_type              ctrl_i,
   input  tsc_lane_type              lane_i,
   output logic                      strobe,
   output logic signed [VALUE_W-1:0] value
);

   localparam int M30_W = SUM_W - OUT_SHIFT;

   tsc_ctrl_type              ctrl_ff;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic                      sum_neg;
   logic [SUM_W-1:0]          mag;
   logic [M30_W-1:0]          m30;
   logic                      res_neg;
   logic                      over;
   logic                      strobe_ff;
   logic signed [VALUE_W-1:0] value_ff, value_in;

   // Fold in the last term
   assign sum_in = tsc_accumulate(lane_i.sum, lane_i.term, lane_i.negate);

   // Take magnitude, truncate to Q.30, apply sign and saturate
   always_comb begin
      sum_neg = sum_ff[SUM_W-1];
      mag = sum_neg ? $unsigned(-sum_ff) : $unsigned(sum_ff);
      m30 = mag[SUM_W-1:OUT_SHIFT];
      res_neg = sum_neg ^ (~ctrl_ff.cosine & ctrl_ff.neg_angle);
      over = |m30[M30_W-1:VALUE_W-1];
      priority if (res_neg && over) begin
         value_in = VALUE_MIN;
      end else if (res_neg) begin
         value_in = -$signed(m30[VALUE_W-1:0]);
      end else if (over) begin
         value_in = VALUE_MAX;
      end else begin
         value_in = $signed(m30[VALUE_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         ctrl_ff <= ctrl_i;
         strobe_ff <= ctrl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      value_ff <= value_in;
   end

   assign strobe = strobe_ff;
   assign value = value_ff;

endmodule

[rtl/taylor_sine_cosine.sv]
// taylor_sine_cosine.sv
// Top level of the Taylor-series sine/cosine unit: front end, a row of
// series cells and the back end. Uses tsc_pkg, tsc_reduce, tsc_cell, tsc_finish.
//
// Usage:
//   Request: drive req_command (0 sine, 1 cosine) and req_angle (signed Q8.24
//   radians) with start high; the transfer happens at the rising edge where
//   start is high and busy is low. busy is low in normal operation, so a new
//   angle may be presented every cycle.
//   Response: rsp_value (signed Q2.30, saturated) is valid for exactly one
//   cycle while rsp_strobe is high; the receiver has no way to stall it.
//   Results come back in request order.
//   Pipeline: one capture stage, five turn-removal stages (one quotient bit
//   each), two squaring stages, four stages per series cell (nine cells), and
//   two output stages. Throughput is one item per cycle while busy is low;
//   each stage is bounded by one 32x32 partial-product multiply or one wide
//   add/compare.
//   Reset: synchronous; drops every item in flight and drives busy from a
//   registered copy of reset.
`timescale 1ns / 1ps
`include "taylor_sine_cosine_defines.svh"

module taylor_sine_cosine import tsc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_command,
   input  logic signed [ANGLE_W-1:0] req_angle,
   output logic                      rsp_strobe,
   output logic signed [VALUE_W-1:0] rsp_value
);

   logic         busy_ff;
   logic         req_accept;
   tsc_ctrl_type ctrl_chain [CELLS+1];
   tsc_lane_type lane_chain [CELLS+1];

   // Register reset as busy, holding off transfers in the cycle after each reset cycle
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy = busy_ff;
   assign req_accept = start & ~busy_ff;

   // Front end: turn removal and squaring
   tsc_reduce u_reduce (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .command (req_command),
      .angle   (req_angle),
      .ctrl_o  (ctrl_chain[0]),
      .lane_o  (lane_chain[0])
   );

   // Row of series cells, each handing the lane to its neighbor
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      tsc_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctrl_i (ctrl_chain[i]),
         .lane_i (lane_chain[i]),
         .ctrl_o (ctrl_chain[i+1]),
         .lane_o (lane_chain[i+1])
      );
   end

   // Back end: last term, truncation to Q2.30, result strobe
   tsc_finish u_finish (
      .clock  (clock),
      .reset  (reset),
      .ctrl_i (ctrl_chain[CELLS]),
      .lane_i (lane_chain[CELLS]),
      .strobe (rsp_strobe),
      .value  (rsp_value)
   );

   // Every accepted transfer yields a result strobe
   `TSC_ASSERT_DELAY(a_result_follows, req_accept, LATENCY, rsp_strobe, "result missing after accepted transfer")

   // Every strobe traces back to an accepted transfer
   `TSC_ASSERT_IMPLY(a_result_has_source, rsp_strobe, $past(req_accept, LATENCY), "result strobe without a transfer")

   // The reduced first term never exceeds one turn
   `TSC_ASSERT_IMPLY(a_first_term_reduced, ctrl_chain[0].valid, lane_chain[0].term <= TWO_PI_Q48, "angle reduction left a full turn")

endmodule
